[hw/rtl/ssim_pkg.sv]
// Shared types, codes and default sizes for the sparse-set index map.
package ssim_pkg;

    localparam int MaxEntities = 1024;
    localparam int DenseDepth  = 1024;
    localparam int SlotW       = 10;
    localparam int IndexW      = 32;
    localparam int TagW        = 32;
    localparam int CountW      = 11;
    localparam int QDepth      = 2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_BIND   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_SLOT    = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IndexW-1:0] entity_index;
        logic [TagW-1:0]   entity_tag;
        logic [SlotW-1:0]  dense_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SlotW-1:0]  slot;
        logic              found;
        logic [CountW-1:0] entry_count;
    } t_out_item;

    // Classified command as it waits between front and back.
    typedef struct packed {
        t_in_item item;
        logic     range_err;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

[hw/rtl/ssim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ssim_front.sv]
// Front end: accepts command beats, checks the index range, queues them for the back end.
module ssim_front
    import ssim_pkg::*;
#(
    parameter int MAX_ENTITIES = MaxEntities
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_pop,
    input  logic     i_hold,
    output logic     o_busy,
    output t_qhead   o_head
);

    localparam int QAW = $clog2(QDepth);
    localparam int QCW = $clog2(QDepth + 1);

    t_cmd             r_q [QDepth];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             push;
    logic             pop;
    t_cmd             cmd_in;

    assign o_busy = (r_cnt == QCW'(QDepth)) || i_hold;
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);

    always_comb begin
        cmd_in.item      = i_item;
        // bind checks its slot first, so the back end orders the two errors
        cmd_in.range_err = (i_item.entity_index >= IndexW'(MAX_ENTITIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QAW'(QDepth - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QAW'(QDepth - 1)) ? '0 : r_rd + QAW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

endmodule

[hw/rtl/ssim_back.sv]
// Back end: sequences sparse and dense table accesses for one command at a time.
module ssim_back
    import ssim_pkg::*;
#(
    parameter int MAX_ENTITIES = MaxEntities,
    parameter int DENSE_DEPTH  = DenseDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qhead    i_head,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int IW  = $clog2(MAX_ENTITIES);
    localparam int SW  = $clog2(DENSE_DEPTH);
    localparam int CW  = $clog2(DENSE_DEPTH + 1);
    localparam int PW  = (CW > SlotW) ? CW : SlotW;
    localparam int SPW = SW + 1;
    localparam int DW  = IW + TagW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_MOVE,
        S_DROP
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_clr_addr, n_clr_addr;
    logic [CW-1:0]     r_count, n_count;
    logic [1:0]        r_mode, n_mode;
    logic [IW-1:0]     r_idx, n_idx;
    logic [TagW-1:0]   r_tag, n_tag;
    logic [SlotW-1:0]  r_pos, n_pos;
    logic              r_range, n_range;
    logic [SW-1:0]     r_hole, n_hole;
    logic              r_valid, n_valid;
    t_out_item         r_result, n_result;

    logic              sp_we;
    logic [IW-1:0]     sp_waddr, sp_raddr;
    logic [SPW-1:0]    sp_wdata, sp_rdata;
    logic              dn_we;
    logic [SW-1:0]     dn_waddr, dn_raddr;
    logic [DW-1:0]     dn_wdata, dn_rdata;

    logic              sp_valid;
    logic [SW-1:0]     sp_slot;
    logic [CW-1:0]     cnt_dec, cnt_inc;
    logic              bind_bad;

    ssim_ram #(.WIDTH(SPW), .DEPTH(MAX_ENTITIES)) u_sparse (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata)
    );

    ssim_ram #(.WIDTH(DW), .DEPTH(DENSE_DEPTH)) u_dense (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_waddr (dn_waddr),
        .i_wdata (dn_wdata),
        .i_raddr (dn_raddr),
        .o_rdata (dn_rdata)
    );

    assign sp_valid = sp_rdata[SW];
    assign sp_slot  = sp_rdata[SW-1:0];
    assign cnt_dec  = r_count - CW'(1);
    assign cnt_inc  = r_count + CW'(1);
    assign bind_bad = (PW'(r_pos) >= PW'(r_count));

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_tag      = r_tag;
        n_pos      = r_pos;
        n_range    = r_range;
        n_hole     = r_hole;
        n_valid    = 1'b0;
        n_result   = r_result;
        o_pop      = 1'b0;
        sp_we      = 1'b0;
        sp_waddr   = r_idx;
        sp_wdata   = '0;
        sp_raddr   = IW'(i_head.cmd.item.entity_index);
        dn_we      = 1'b0;
        dn_waddr   = SW'(r_pos);
        dn_wdata   = {r_tag, r_idx};
        dn_raddr   = SW'(cnt_dec);

        unique case (r_state)
            S_CLEAR: begin
                // sweep the sparse table to invalid, one entry a cycle
                sp_we      = 1'b1;
                sp_waddr   = r_clr_addr;
                n_clr_addr = r_clr_addr + IW'(1);
                if (r_clr_addr == IW'(MAX_ENTITIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_mode  = i_head.cmd.item.mode;
                    n_idx   = IW'(i_head.cmd.item.entity_index);
                    n_tag   = i_head.cmd.item.entity_tag;
                    n_pos   = i_head.cmd.item.dense_position;
                    n_range = i_head.cmd.range_err;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state              = S_IDLE;
                n_valid              = 1'b1;
                n_result.status      = ST_OK;
                n_result.slot        = '0;
                n_result.found       = 1'b0;
                n_result.entry_count = CountW'(r_count);
                if (r_mode == MODE_BIND) begin
                    if (bind_bad) begin
                        n_result.status = ST_SLOT;
                    end else if (r_range) begin
                        n_result.status = ST_RANGE;
                    end else begin
                        dn_we          = 1'b1;
                        sp_we          = 1'b1;
                        sp_wdata       = {1'b1, SW'(r_pos)};
                        n_result.slot  = r_pos;
                        n_result.found = 1'b1;
                    end
                end else if (r_range) begin
                    n_result.status = ST_RANGE;
                end else begin
                    unique case (r_mode)
                        MODE_INSERT: begin
                            if (sp_valid) begin
                                n_result.status = ST_PRESENT;
                                n_result.slot   = SlotW'(sp_slot);
                                n_result.found  = 1'b1;
                            end else if (r_count >= CW'(DENSE_DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                dn_we                = 1'b1;
                                dn_waddr             = SW'(r_count);
                                sp_we                = 1'b1;
                                sp_wdata             = {1'b1, SW'(r_count)};
                                n_count              = cnt_inc;
                                n_result.slot        = SlotW'(r_count);
                                n_result.found       = 1'b1;
                                n_result.entry_count = CountW'(cnt_inc);
                            end
                        end
                        MODE_FIND: begin
                            if (sp_valid) begin
                                n_result.slot  = SlotW'(sp_slot);
                                n_result.found = 1'b1;
                            end else begin
                                n_result.status = ST_ABSENT;
                            end
                        end
                        MODE_REMOVE: begin
                            if (!sp_valid) begin
                                n_result.status = ST_ABSENT;
                            end else if (CW'(sp_slot) >= r_count) begin
                                // stale entry left by a bind: drop it only
                                sp_we           = 1'b1;
                                n_result.status = ST_ABSENT;
                            end else if (sp_slot != SW'(cnt_dec)) begin
                                // dense read of the last slot is in flight
                                n_valid = 1'b0;
                                n_hole  = sp_slot;
                                n_state = S_MOVE;
                            end else begin
                                sp_we                = 1'b1;
                                n_count              = cnt_dec;
                                n_result.entry_count = CountW'(cnt_dec);
                            end
                        end
                        default: begin
                            n_result.status = ST_SLOT;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                // move the last handle into the hole and repair its sparse entry
                dn_we    = 1'b1;
                dn_waddr = r_hole;
                dn_wdata = dn_rdata;
                sp_we    = 1'b1;
                sp_waddr = dn_rdata[IW-1:0];
                sp_wdata = {1'b1, r_hole};
                n_state  = S_DROP;
            end
            S_DROP: begin
                sp_we                = 1'b1;
                n_count              = cnt_dec;
                n_valid              = 1'b1;
                n_result.status      = ST_OK;
                n_result.slot        = '0;
                n_result.found       = 1'b0;
                n_result.entry_count = CountW'(cnt_dec);
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_valid    <= n_valid;
        end
        r_mode   <= n_mode;
        r_idx    <= n_idx;
        r_tag    <= n_tag;
        r_pos    <= n_pos;
        r_range  <= n_range;
        r_hole   <= n_hole;
        r_result <= n_result;
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_valid;
    assign o_result   = r_result;

endmodule

[hw/rtl/sparse_set_index_map_top.sv]
// An accepted beat is queued, popped by the back end in S_IDLE and looked up in S_LOOK, which
// registers the result strobe; a remove that moves the last slot goes on through S_MOVE and
// S_DROP, which strobes instead. The back end sequences its sparse and dense RAM accesses for
// one beat at a time; a 2-deep queue takes beats meanwhile. Reset: synchronous, active low;
// busy stays high while the sparse table is swept to invalid, and the count restarts at zero.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module sparse_set_index_map_top
    import ssim_pkg::*;
#(
    parameter int MAX_ENTITIES = MaxEntities,
    parameter int DENSE_DEPTH  = DenseDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    t_qhead head;
    logic   pop;
    logic   clearing;

    ssim_front #(.MAX_ENTITIES(MAX_ENTITIES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_pop   (pop),
        .i_hold  (clearing),
        .o_busy  (busy),
        .o_head  (head)
    );

    ssim_back #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .DENSE_DEPTH  (DENSE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

[hw/rtl/ssim_checker.sv]
// Port-level checks for the sparse-set index map, bound to the top level.
module ssim_checker
    import ssim_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status <= ST_SLOT))
        else $error("result status code out of range");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.found) |->
            (o_result.status == ST_OK || o_result.status == ST_PRESENT))
        else $error("found set on an error result");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |-> (o_result.slot == '0))
        else $error("nonzero slot without found");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes on back-to-back cycles");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("not busy while the table sweep runs");

endmodule

bind sparse_set_index_map_top ssim_checker u_ssim_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
